FILE: rtl/core/tmie_pkg.sv
// ----------------------------------------------------------------------------
// tmie_pkg
// Shared types, codes and helpers for the tape machine instruction executor.
// ----------------------------------------------------------------------------
package tmie_pkg;

  localparam int TAPE_DEPTH = 1024;
  localparam int ADDR_W     = $clog2(TAPE_DEPTH);
  localparam int CELLS_W    = ADDR_W + 1;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_EXEC   = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_END    = 2'd3;

  localparam logic [3:0] OP_LEFT  = 4'd0;
  localparam logic [3:0] OP_RIGHT = 4'd1;
  localparam logic [3:0] OP_HALT  = 4'd2;
  localparam logic [3:0] OP_FAIL  = 4'd3;
  localparam logic [3:0] OP_DRAW  = 4'd4;
  localparam logic [3:0] OP_ALPHA = 4'd5;
  localparam logic [3:0] OP_BRAE  = 4'd6;
  localparam logic [3:0] OP_BRANE = 4'd7;
  localparam logic [3:0] OP_BRA   = 4'd8;
  localparam logic [3:0] OP_CMP   = 4'd9;

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_HALT = 2'd1;
  localparam logic [1:0] ST_FAIL = 2'd2;

  localparam logic [1:0] CMP_NE   = 2'd0;
  localparam logic [1:0] CMP_EQ   = 2'd1;
  localparam logic [1:0] CMP_NONE = 2'd2;

  localparam logic [7:0] SYM_SPACE = 8'h20;
  localparam logic [7:0] SYM_BLANK = 8'h00;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  symbol;
    logic [15:0] instruction;
    logic [9:0]  cell_index;
  } in_item_t;

  typedef struct packed {
    logic [11:0] next_pc;
    logic [1:0]  run_status;
    logic [9:0]  head_position;
    logic [10:0] tape_length;
    logic [31:0] move_count;
    logic [31:0] instruction_count;
    logic [31:0] total_moves;
    logic [31:0] total_instructions;
    logic [7:0]  cell_symbol;
  } out_item_t;

  // decoded word handed from front to back
  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  symbol;
    logic [3:0]  op;
    logic [7:0]  op_sym;
    logic [11:0] target;
    logic [9:0]  cell_index;
  } q_item_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

FILE: rtl/core/tmie_ram.sv
// ----------------------------------------------------------------------------
// tmie_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tmie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/tmie_front.sv
// ----------------------------------------------------------------------------
// tmie_front
// Accepts input words, splits the instruction into fields and queues them.
// ----------------------------------------------------------------------------
module tmie_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tmie_pkg::in_item_t in_data,
  output logic               q_valid,
  output tmie_pkg::q_item_t  q_item,
  input  logic               q_pop
);

  tmie_pkg::q_item_t slot_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        count_r;
  tmie_pkg::q_item_t dec;
  logic              push;

  always_comb begin
    dec.cmd        = in_data.cmd;
    dec.symbol     = in_data.symbol;
    dec.op         = in_data.instruction[15:12];
    dec.op_sym     = in_data.instruction[7:0];
    dec.target     = in_data.instruction[11:0];
    dec.cell_index = in_data.cell_index;
  end

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

FILE: rtl/core/tmie_back.sv
// ----------------------------------------------------------------------------
// tmie_back
// Carries out queued words against the tape store and machine state.
// ----------------------------------------------------------------------------
module tmie_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  tmie_pkg::q_item_t   q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output tmie_pkg::out_item_t out_data
);

  localparam int AW = tmie_pkg::ADDR_W;
  localparam int CW = tmie_pkg::CELLS_W;
  localparam logic [CW-1:0] FULL = CW'(tmie_pkg::TAPE_DEPTH);

  localparam logic PH_FETCH = 1'b0;
  localparam logic PH_EXEC  = 1'b1;

  logic                phase_r, phase_nxt;
  tmie_pkg::q_item_t   item_r, item_nxt;
  logic [AW-1:0]       origin_r, origin_nxt;
  logic [CW-1:0]       cells_r, cells_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [11:0]         pc_r, pc_nxt;
  logic [1:0]          cmpr_r, cmpr_nxt;
  logic [255:0]        alpha_r, alpha_nxt;
  logic [1:0]          status_r, status_nxt;
  logic [31:0]         rm_r, rm_nxt, ri_r, ri_nxt, sm_r, sm_nxt, si_r, si_nxt;
  logic                out_valid_r, out_valid_nxt;
  tmie_pkg::out_item_t out_r, out_nxt;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [7:0]        wdata, rdata;
  logic              out_free;
  logic [CW-1:0]     c;
  logic [7:0]        here, rd_sym;
  tmie_pkg::q_item_t rd_item;

  tmie_ram #(.WIDTH(8), .DEPTH(tmie_pkg::TAPE_DEPTH)) u_tape (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // while a word waits in the execute phase its own read is repeated
  assign rd_item = (phase_r == PH_FETCH) ? q_item : item_r;

  always_comb begin
    phase_nxt     = phase_r;
    item_nxt      = item_r;
    origin_nxt    = origin_r;
    cells_nxt     = cells_r;
    head_nxt      = head_r;
    pc_nxt        = pc_r;
    cmpr_nxt      = cmpr_r;
    alpha_nxt     = alpha_r;
    status_nxt    = status_r;
    rm_nxt        = rm_r;
    ri_nxt        = ri_r;
    sm_nxt        = sm_r;
    si_nxt        = si_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    we            = 1'b0;
    waddr         = origin_r;
    wdata         = tmie_pkg::SYM_BLANK;
    raddr         = (rd_item.cmd == tmie_pkg::CMD_READ) ?
                    origin_r + rd_item.cell_index[AW-1:0] : origin_r + head_r;
    c             = (cells_r == '0) ? CW'(1) : cells_r;
    here          = (cells_r == '0) ? tmie_pkg::SYM_SPACE : rdata;
    rd_sym        = tmie_pkg::SYM_BLANK;

    if (phase_r == PH_FETCH) begin
      if (q_valid) begin
        q_pop     = 1'b1;
        phase_nxt = PH_EXEC;
        item_nxt  = q_item;
        // empty tape gets its space cell before the instruction runs
        if (q_item.cmd == tmie_pkg::CMD_EXEC && status_r == tmie_pkg::ST_RUN &&
            cells_r == '0) begin
          we    = 1'b1;
          wdata = tmie_pkg::SYM_SPACE;
        end
      end
    end else if (out_free) begin
      phase_nxt = PH_FETCH;
      unique case (item_r.cmd)
        tmie_pkg::CMD_APPEND: begin
          if (status_r == tmie_pkg::ST_RUN && cells_r < FULL) begin
            we        = 1'b1;
            waddr     = origin_r + cells_r[AW-1:0];
            wdata     = item_r.symbol;
            cells_nxt = cells_r + CW'(1);
          end
        end
        tmie_pkg::CMD_EXEC: begin
          if (status_r == tmie_pkg::ST_RUN) begin
            cells_nxt = c;
            ri_nxt    = tmie_pkg::sat_add(ri_r, 32'd1);
            pc_nxt    = pc_r + 12'd1;
            unique case (item_r.op)
              tmie_pkg::OP_LEFT: begin
                if (head_r == '0) begin
                  if (c >= FULL) begin
                    status_nxt = tmie_pkg::ST_FAIL;
                  end else begin
                    origin_nxt = origin_r - AW'(1);
                    we         = 1'b1;
                    waddr      = origin_r - AW'(1);
                    cells_nxt  = c + CW'(1);
                    rm_nxt     = tmie_pkg::sat_add(rm_r, 32'd1);
                  end
                end else begin
                  head_nxt = head_r - AW'(1);
                  rm_nxt   = tmie_pkg::sat_add(rm_r, 32'd1);
                end
              end
              tmie_pkg::OP_RIGHT: begin
                if ({1'b0, head_r} + CW'(1) >= c && c >= FULL) begin
                  status_nxt = tmie_pkg::ST_FAIL;
                end else begin
                  if ({1'b0, head_r} + CW'(1) >= c) begin
                    we        = 1'b1;
                    waddr     = origin_r + c[AW-1:0];
                    cells_nxt = c + CW'(1);
                  end
                  head_nxt = head_r + AW'(1);
                  rm_nxt   = tmie_pkg::sat_add(rm_r, 32'd1);
                end
              end
              tmie_pkg::OP_HALT: status_nxt = tmie_pkg::ST_HALT;
              tmie_pkg::OP_DRAW: begin
                if (!alpha_r[item_r.op_sym]) begin
                  status_nxt = tmie_pkg::ST_FAIL;
                end else begin
                  we    = 1'b1;
                  waddr = origin_r + head_r;
                  wdata = item_r.op_sym;
                end
              end
              tmie_pkg::OP_ALPHA: alpha_nxt[item_r.op_sym] = 1'b1;
              tmie_pkg::OP_BRAE, tmie_pkg::OP_BRANE: begin
                if ((item_r.op == tmie_pkg::OP_BRAE && cmpr_r == tmie_pkg::CMP_EQ) ||
                    (item_r.op == tmie_pkg::OP_BRANE && cmpr_r == tmie_pkg::CMP_NE)) begin
                  pc_nxt   = item_r.target;
                  cmpr_nxt = tmie_pkg::CMP_NONE;
                end
              end
              tmie_pkg::OP_BRA: pc_nxt = item_r.target;
              tmie_pkg::OP_CMP: begin
                if (!alpha_r[item_r.op_sym] || !alpha_r[here]) begin
                  status_nxt = tmie_pkg::ST_FAIL;
                end else begin
                  cmpr_nxt = (here == item_r.op_sym) ? tmie_pkg::CMP_EQ : tmie_pkg::CMP_NE;
                end
              end
              default: status_nxt = tmie_pkg::ST_FAIL;
            endcase
          end
        end
        tmie_pkg::CMD_READ: begin
          if ({1'b0, item_r.cell_index} < cells_r) rd_sym = rdata;
        end
        default: begin
          sm_nxt     = tmie_pkg::sat_add(sm_r, rm_r);
          si_nxt     = tmie_pkg::sat_add(si_r, ri_r);
          origin_nxt = '0;
          cells_nxt  = '0;
          head_nxt   = '0;
          pc_nxt     = '0;
          cmpr_nxt   = tmie_pkg::CMP_NONE;
          alpha_nxt  = '0;
          status_nxt = tmie_pkg::ST_RUN;
          rm_nxt     = '0;
          ri_nxt     = '0;
        end
      endcase
      out_valid_nxt              = 1'b1;
      out_nxt.next_pc            = pc_nxt;
      out_nxt.run_status         = status_nxt;
      out_nxt.head_position      = head_nxt;
      out_nxt.tape_length        = cells_nxt;
      out_nxt.move_count         = rm_nxt;
      out_nxt.instruction_count  = ri_nxt;
      out_nxt.total_moves        = sm_nxt;
      out_nxt.total_instructions = si_nxt;
      out_nxt.cell_symbol        = rd_sym;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FETCH;
      origin_r    <= '0;
      cells_r     <= '0;
      head_r      <= '0;
      pc_r        <= '0;
      cmpr_r      <= tmie_pkg::CMP_NONE;
      alpha_r     <= '0;
      status_r    <= tmie_pkg::ST_RUN;
      rm_r        <= '0;
      ri_r        <= '0;
      sm_r        <= '0;
      si_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      origin_r    <= origin_nxt;
      cells_r     <= cells_nxt;
      head_r      <= head_nxt;
      pc_r        <= pc_nxt;
      cmpr_r      <= cmpr_nxt;
      alpha_r     <= alpha_nxt;
      status_r    <= status_nxt;
      rm_r        <= rm_nxt;
      ri_r        <= ri_nxt;
      sm_r        <= sm_nxt;
      si_r        <= si_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/core/tape_machine_instruction_executor.sv
// ----------------------------------------------------------------------------
// tape_machine_instruction_executor
// Tape machine: appends symbols, runs instructions, reads cells, ends runs.
// ----------------------------------------------------------------------------
// Input words (in_valid/in_stall/in_data) carry a command: append a symbol,
// execute an instruction, read a tape cell or end the run. Every input word
// gives exactly one result word on out_valid/out_stall/out_data, holding
// the machine state after that word, in order.
// A two-entry queue sits behind the input, so words keep being taken while
// the executor works or a result waits. The executor takes each word
// through a fetch phase, which reads the tape memory at the head or the
// requested cell, then an execute phase, which computes and writes back; on
// the single tape memory it fetches no new word until the last has executed.
// With an empty queue a word passes the queue slot, the fetch-phase tape
// read and the result register before out_valid rises.
// When the receiver stalls, the result register holds, the executor waits,
// and once the queue fills in_stall rises.
// Reset clears the queue, the result register and the machine state; the
// tape memory itself is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module tape_machine_instruction_executor (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tmie_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tmie_pkg::out_item_t out_data
);

  logic              q_valid, q_pop;
  tmie_pkg::q_item_t q_item;

  tmie_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  tmie_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: bench/tape_machine_instruction_executor_test.sv
// ----------------------------------------------------------------------------
// tape_machine_instruction_executor_test
// Self-checking bench: directed tape-machine programs, then random runs of
// mostly well-formed instruction streams, with sender and receiver idling,
// a long receiver hold-off and a drain pause. Results are checked against
// a built-in model of the machine, word by word, in order.
// ----------------------------------------------------------------------------
module tape_machine_instruction_executor_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [10:0] FULL = 11'(tmie_pkg::TAPE_DEPTH);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  tmie_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tmie_pkg::out_item_t out_data;

  tape_machine_instruction_executor dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  logic [7:0]  m_tape [tmie_pkg::TAPE_DEPTH];
  logic [9:0]  m_origin;
  logic [10:0] m_cells;
  logic [9:0]  m_head;
  logic [11:0] m_pc;
  logic [1:0]  m_cmp;
  logic        m_alpha [256];
  logic [1:0]  m_status;
  logic [31:0] m_moves, m_instrs, m_sum_moves, m_sum_instrs;

  tmie_pkg::out_item_t expected_words[$];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int runs_ended = 0;
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_off = 1'b0;
  longint cycles = 0;

  function automatic logic [9:0] phys(input logic [10:0] logical);
    return m_origin + logical[9:0];
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic clear_run_state();
    m_origin = '0; m_cells = '0; m_head = '0; m_pc = '0; m_cmp = tmie_pkg::CMP_NONE;
    foreach (m_alpha[i]) m_alpha[i] = 1'b0;
    m_status = tmie_pkg::ST_RUN; m_moves = '0; m_instrs = '0;
  endtask

  task automatic run_instruction(input logic [15:0] w);
    logic [3:0] op;
    logic [7:0] sym, here;
    logic [11:0] nxt;
    op = w[15:12]; sym = w[7:0]; nxt = m_pc + 12'd1;
    if (m_cells == '0) begin
      m_tape[phys(11'd0)] = tmie_pkg::SYM_SPACE; m_cells = 11'd1; m_head = '0;
    end
    m_instrs = sat_inc(m_instrs, 32'd1);
    case (op)
      tmie_pkg::OP_LEFT: begin
        if (m_head == '0) begin
          if (m_cells >= FULL) m_status = tmie_pkg::ST_FAIL;
          else begin
            m_origin = m_origin - 10'd1; m_tape[m_origin] = tmie_pkg::SYM_BLANK;
            m_cells++; m_moves = sat_inc(m_moves, 32'd1);
          end
        end else begin
          m_head--; m_moves = sat_inc(m_moves, 32'd1);
        end
      end
      tmie_pkg::OP_RIGHT: begin
        if ({1'b0, m_head} + 11'd1 >= m_cells && m_cells >= FULL)
          m_status = tmie_pkg::ST_FAIL;
        else begin
          if ({1'b0, m_head} + 11'd1 >= m_cells) begin
            m_tape[phys(m_cells)] = tmie_pkg::SYM_BLANK; m_cells++;
          end
          m_head++; m_moves = sat_inc(m_moves, 32'd1);
        end
      end
      tmie_pkg::OP_HALT: m_status = tmie_pkg::ST_HALT;
      tmie_pkg::OP_DRAW: begin
        if (!m_alpha[sym]) m_status = tmie_pkg::ST_FAIL;
        else m_tape[phys({1'b0, m_head})] = sym;
      end
      tmie_pkg::OP_ALPHA: m_alpha[sym] = 1'b1;
      tmie_pkg::OP_BRAE, tmie_pkg::OP_BRANE: begin
        if (m_cmp == ((op == tmie_pkg::OP_BRAE) ? tmie_pkg::CMP_EQ : tmie_pkg::CMP_NE)) begin
          nxt = w[11:0]; m_cmp = tmie_pkg::CMP_NONE;
        end
      end
      tmie_pkg::OP_BRA: nxt = w[11:0];
      tmie_pkg::OP_CMP: begin
        here = m_tape[phys({1'b0, m_head})];
        if (!m_alpha[sym] || !m_alpha[here]) m_status = tmie_pkg::ST_FAIL;
        else m_cmp = (here == sym) ? tmie_pkg::CMP_EQ : tmie_pkg::CMP_NE;
      end
      default: m_status = tmie_pkg::ST_FAIL;
    endcase
    m_pc = nxt;
  endtask

  task automatic predict_word(input tmie_pkg::in_item_t it);
    tmie_pkg::out_item_t r;
    logic [7:0] rd_sym;
    rd_sym = '0;
    case (it.cmd)
      tmie_pkg::CMD_APPEND: if (m_status == tmie_pkg::ST_RUN && m_cells < FULL) begin
        m_tape[phys(m_cells)] = it.symbol; m_cells++;
      end
      tmie_pkg::CMD_EXEC: if (m_status == tmie_pkg::ST_RUN) run_instruction(it.instruction);
      tmie_pkg::CMD_READ: if ({1'b0, it.cell_index} < m_cells)
        rd_sym = m_tape[phys({1'b0, it.cell_index})];
      default: begin
        m_sum_moves = sat_inc(m_sum_moves, m_moves);
        m_sum_instrs = sat_inc(m_sum_instrs, m_instrs);
        clear_run_state();
        runs_ended++;
      end
    endcase
    r.next_pc = m_pc; r.run_status = m_status; r.head_position = m_head;
    r.tape_length = m_cells; r.move_count = m_moves; r.instruction_count = m_instrs;
    r.total_moves = m_sum_moves; r.total_instructions = m_sum_instrs;
    r.cell_symbol = rd_sym;
    expected_words = {expected_words, r};
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at result %0d: %s got %0h want %0h", checked, what, got, want);
    errors++;
  endtask

  // checker and receiver stall
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) report_mismatch("unexpected word", 32'd0, 32'd0);
        else begin
          tmie_pkg::out_item_t e;
          e = expected_words.pop_front();
          if (out_data.next_pc !== e.next_pc)
            report_mismatch("next_pc", 32'(out_data.next_pc), 32'(e.next_pc));
          if (out_data.run_status !== e.run_status)
            report_mismatch("run_status", 32'(out_data.run_status), 32'(e.run_status));
          if (out_data.head_position !== e.head_position)
            report_mismatch("head_position", 32'(out_data.head_position),
                            32'(e.head_position));
          if (out_data.tape_length !== e.tape_length)
            report_mismatch("tape_length", 32'(out_data.tape_length), 32'(e.tape_length));
          if (out_data.move_count !== e.move_count)
            report_mismatch("move_count", out_data.move_count, e.move_count);
          if (out_data.instruction_count !== e.instruction_count)
            report_mismatch("instruction_count", out_data.instruction_count,
                            e.instruction_count);
          if (out_data.total_moves !== e.total_moves)
            report_mismatch("total_moves", out_data.total_moves, e.total_moves);
          if (out_data.total_instructions !== e.total_instructions)
            report_mismatch("total_instructions", out_data.total_instructions,
                            e.total_instructions);
          if (out_data.cell_symbol !== e.cell_symbol)
            report_mismatch("cell_symbol", 32'(out_data.cell_symbol), 32'(e.cell_symbol));
          checked++;
        end
      end
      out_stall <= hold_off || ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    if (cycles > 3000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // valid stays up after an accept until the next word or an idle gap
  task automatic send_word(input tmie_pkg::in_item_t it);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(it);
    sent++;
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
  endtask

  task automatic send_cmd(input logic [1:0] c, input logic [7:0] s,
                          input logic [15:0] w, input logic [9:0] idx);
    tmie_pkg::in_item_t it;
    it.cmd = c; it.symbol = s; it.instruction = w; it.cell_index = idx;
    send_word(it);
  endtask

  task automatic exec_op(input logic [3:0] op, input logic [11:0] low);
    send_cmd(tmie_pkg::CMD_EXEC, 8'($urandom), {op, low}, 10'($urandom));
  endtask

  task automatic wait_drained();
    idle_input();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_directed();
    // execute on empty tape inserts a space
    exec_op(tmie_pkg::OP_ALPHA, 12'h020);
    exec_op(tmie_pkg::OP_ALPHA, 12'h0ff);
    exec_op(tmie_pkg::OP_CMP, 12'h020);
    exec_op(tmie_pkg::OP_BRAE, 12'hfff);
    exec_op(tmie_pkg::OP_CMP, 12'h0ff);
    exec_op(tmie_pkg::OP_BRANE, 12'h000);
    exec_op(tmie_pkg::OP_LEFT, 12'h000);           // grows at the front
    exec_op(tmie_pkg::OP_RIGHT, 12'h000);
    exec_op(tmie_pkg::OP_RIGHT, 12'h000);          // grows at the back
    exec_op(tmie_pkg::OP_DRAW, 12'h0ff);
    send_cmd(tmie_pkg::CMD_READ, 8'h00, 16'h0, 10'd2);
    send_cmd(tmie_pkg::CMD_READ, 8'h00, 16'h0, 10'h3ff); // out of range
    exec_op(tmie_pkg::OP_BRA, 12'habc);
    exec_op(tmie_pkg::OP_DRAW, 12'h011);           // not in alphabet: fails
    send_cmd(tmie_pkg::CMD_APPEND, 8'hff, 16'h0, 10'd0); // ignored after fail
    send_cmd(tmie_pkg::CMD_END, 8'h00, 16'hffff, 10'd0);
    send_cmd(tmie_pkg::CMD_APPEND, 8'hff, 16'h0, 10'd0);
    send_cmd(tmie_pkg::CMD_APPEND, 8'h00, 16'h0, 10'd0);
    exec_op(tmie_pkg::OP_FAIL, 12'h000);
    send_cmd(tmie_pkg::CMD_END, 8'h00, 16'h0, 10'd0);
    exec_op(4'hf, 12'hfff);                        // unknown opcode
    send_cmd(tmie_pkg::CMD_END, 8'h00, 16'h0, 10'd0);
    exec_op(tmie_pkg::OP_HALT, 12'h000);
    exec_op(tmie_pkg::OP_RIGHT, 12'h000);          // ignored after halt
    send_cmd(tmie_pkg::CMD_END, 8'h00, 16'h0, 10'd0);
  endtask

  task automatic test_overflow();
    // fill the tape, then try to grow it at the front
    for (int i = 0; i < tmie_pkg::TAPE_DEPTH + 2; i++)
      send_cmd(tmie_pkg::CMD_APPEND, 8'($urandom), 16'h0, 10'd0);
    send_cmd(tmie_pkg::CMD_READ, 8'h00, 16'h0, 10'h3ff);
    exec_op(tmie_pkg::OP_RIGHT, 12'h000);
    exec_op(tmie_pkg::OP_LEFT, 12'h000);
    exec_op(tmie_pkg::OP_LEFT, 12'h000);
    send_cmd(tmie_pkg::CMD_END, 8'h00, 16'h0, 10'd0);
    // short tape growing at the back
    repeat (3) send_cmd(tmie_pkg::CMD_APPEND, 8'($urandom), 16'h0, 10'd0);
    repeat (6) exec_op(tmie_pkg::OP_RIGHT, 12'h000);
    send_cmd(tmie_pkg::CMD_END, 8'h00, 16'h0, 10'd0);
  endtask

  // mostly sensible programs over a small alphabet, with some noise
  task automatic random_run();
    int len;
    logic [7:0] syms [4];
    len = $urandom_range(10, 60);
    foreach (syms[i]) syms[i] = (i == 0) ? tmie_pkg::SYM_SPACE : 8'($urandom);
    repeat ($urandom_range(0, 6)) send_cmd(tmie_pkg::CMD_APPEND, syms[$urandom_range(3)],
                                           16'($urandom), 10'($urandom));
    foreach (syms[i])
      if ($urandom_range(9) != 0) exec_op(tmie_pkg::OP_ALPHA, {4'($urandom), syms[i]});
    for (int i = 0; i < len; i++) begin
      int pick;
      pick = $urandom_range(99);
      if (pick < 3) send_cmd(tmie_pkg::CMD_EXEC, 8'($urandom), 16'($urandom), 10'($urandom));
      else if (pick < 12) send_cmd(tmie_pkg::CMD_READ, 8'($urandom), 16'($urandom),
                                   (pick < 9) ? 10'($urandom_range(15)) : 10'($urandom));
      else if (pick < 15) send_cmd(tmie_pkg::CMD_APPEND, 8'($urandom), 16'($urandom),
                                   10'($urandom));
      else if (pick < 16) exec_op(tmie_pkg::OP_HALT, 12'($urandom));
      else begin
        logic [3:0] op;
        op = 4'($urandom_range(9));
        if (op == tmie_pkg::OP_HALT || op == tmie_pkg::OP_FAIL) op = tmie_pkg::OP_RIGHT;
        exec_op(op, {4'($urandom), syms[$urandom_range(3)]});
      end
    end
    send_cmd(tmie_pkg::CMD_END, 8'($urandom), 16'($urandom), 10'($urandom));
  endtask

  task automatic test_random(input int n);
    int start;
    start = sent;
    while (sent - start < n) random_run();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (20) exec_op(tmie_pkg::OP_RIGHT, 12'h000);
    join
    wait_drained();
    send_cmd(tmie_pkg::CMD_END, 8'h00, 16'h0, 10'd0);
  endtask

  initial begin
    for (int i = 0; i < tmie_pkg::TAPE_DEPTH; i++) m_tape[i] = '0;
    clear_run_state();
    m_sum_moves = '0; m_sum_instrs = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    send_idle = 7; recv_idle = 55;
    test_random(290);
    test_backpressure();
    wait_drained();
    send_idle = 55; recv_idle = 7;
    test_random(290);
    send_idle = 0; recv_idle = 0;
    test_overflow();
    test_random(290);
    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d words, %0d results checked, %0d runs ended", sent, checked,
             runs_ended);
    $display("directed ops, tape growth and overflow, idling and a long hold-off");
    if (errors == 0 && expected_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d left over", errors, expected_words.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
